// File: sv/awa_pkg.sv
// ----------------------------------------------------------------------------
// awa_pkg: shared types and constants for the aligned window allocator
// Holds the field widths, the request and response beats, the window view
// passed from the register file to the sequencer, and the adder opcodes.
// ----------------------------------------------------------------------------
package awa_pkg;

   localparam int NUM_WINDOWS   = 2;
   localparam int ADDR_WIDTH    = 48;
   localparam int WIN_IDX_WIDTH = 1;
   localparam int FILL_WIDTH    = ADDR_WIDTH + 1;
   localparam int OFF_WIDTH     = ADDR_WIDTH + 2;
   localparam int CALC_WIDTH    = ADDR_WIDTH + 3;
   localparam int KIND_WIDTH    = 2;
   localparam int STATUS_WIDTH  = 2;
   localparam int PADDR_WIDTH   = 6;
   localparam int PDATA_WIDTH   = 64;

   // Window and request kinds.
   localparam logic [KIND_WIDTH-1:0] KIND_OFF = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_IO  = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_MEM = 2'd2;

   // Response status codes.
   localparam logic [STATUS_WIDTH-1:0] STATUS_GRANT   = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_NOSPACE = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_ZERO    = 2'd2;

   // Register slots within one window.
   localparam logic [1:0] REG_TYPE      = 2'd0;
   localparam logic [1:0] REG_BUS_BASE  = 2'd1;
   localparam logic [1:0] REG_HOST_BASE = 2'd2;
   localparam logic [1:0] REG_LENGTH    = 2'd3;

   typedef struct packed {
      logic [KIND_WIDTH-1:0] req_kind;
      logic [ADDR_WIDTH-1:0] req_size;
   } req_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic [ADDR_WIDTH-1:0]   bus_addr;
      logic [ADDR_WIDTH-1:0]   host_addr;
   } rsp_type;

   typedef struct packed {
      logic [KIND_WIDTH-1:0] kind;
      logic [ADDR_WIDTH-1:0] bus_base;
      logic [ADDR_WIDTH-1:0] host_origin;
      logic [ADDR_WIDTH-1:0] size;
      logic [FILL_WIDTH-1:0] fill;
   } win_view_type;

   typedef struct packed {
      logic                     en;
      logic [WIN_IDX_WIDTH-1:0] win;
      logic [FILL_WIDTH-1:0]    value;
   } fill_upd_type;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0] size;
      logic [ADDR_WIDTH-1:0] mask;
      logic [FILL_WIDTH-1:0] fill;
      logic [OFF_WIDTH-1:0]  off;
      logic [ADDR_WIDTH-1:0] bus_base;
      logic [ADDR_WIDTH-1:0] host_origin;
   } alu_src_type;

   typedef enum logic [2:0] {
      ALU_NOP,
      ALU_DEC,
      ALU_ROUND,
      ALU_END,
      ALU_BUS,
      ALU_HOST
   } alu_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MASK,
      ST_SELECT,
      ST_ROUND,
      ST_END,
      ST_BUS,
      ST_HOST,
      ST_DONE
   } seq_state_type;

endpackage

// File: sv/awa_csr.sv
// ----------------------------------------------------------------------------
// awa_csr: window register file and fill offsets
// Decodes the APB-style port, holds the per-window registers and fill
// offsets, and presents the window that the sequencer is working on.
// ----------------------------------------------------------------------------
module awa_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [awa_pkg::PADDR_WIDTH-1:0]  paddr,
   input  logic [awa_pkg::PDATA_WIDTH-1:0]  pwdata,
   output logic [awa_pkg::PDATA_WIDTH-1:0]  prdata,
   input  logic [awa_pkg::WIN_IDX_WIDTH-1:0] win_sel,
   input  awa_pkg::fill_upd_type            fill_upd,
   output awa_pkg::win_view_type            win_view
);
   import awa_pkg::*;

   logic [KIND_WIDTH-1:0] type_ff [NUM_WINDOWS];
   logic [KIND_WIDTH-1:0] type_in [NUM_WINDOWS];
   logic [ADDR_WIDTH-1:0] bus_ff  [NUM_WINDOWS];
   logic [ADDR_WIDTH-1:0] bus_in  [NUM_WINDOWS];
   logic [ADDR_WIDTH-1:0] host_ff [NUM_WINDOWS];
   logic [ADDR_WIDTH-1:0] host_in [NUM_WINDOWS];
   logic [ADDR_WIDTH-1:0] size_ff [NUM_WINDOWS];
   logic [ADDR_WIDTH-1:0] size_in [NUM_WINDOWS];
   logic [FILL_WIDTH-1:0] fill_ff [NUM_WINDOWS];
   logic [FILL_WIDTH-1:0] fill_in [NUM_WINDOWS];

   logic                     wr_en;
   logic [WIN_IDX_WIDTH-1:0] wr_win;
   logic [1:0]               wr_reg;

   assign wr_en  = psel & penable & pwrite;
   assign wr_win = paddr[5];
   assign wr_reg = paddr[4:3];

   always_comb begin
      for (int w = 0; w < NUM_WINDOWS; w++) begin
         type_in[w] = type_ff[w];
         bus_in[w]  = bus_ff[w];
         host_in[w] = host_ff[w];
         size_in[w] = size_ff[w];
         fill_in[w] = fill_ff[w];
         if (fill_upd.en && fill_upd.win == WIN_IDX_WIDTH'(w)) begin
            fill_in[w] = fill_upd.value;
         end
         if (wr_en && wr_win == WIN_IDX_WIDTH'(w)) begin
            unique case (wr_reg)
               REG_TYPE:      type_in[w] = pwdata[KIND_WIDTH-1:0];
               REG_BUS_BASE:  bus_in[w]  = pwdata[ADDR_WIDTH-1:0];
               REG_HOST_BASE: host_in[w] = pwdata[ADDR_WIDTH-1:0];
               REG_LENGTH: begin
                  // A new window size starts the window over from its base.
                  size_in[w] = pwdata[ADDR_WIDTH-1:0];
                  fill_in[w] = '0;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < NUM_WINDOWS; w++) begin
            type_ff[w] <= KIND_OFF;
            bus_ff[w]  <= '0;
            host_ff[w] <= '0;
            size_ff[w] <= '0;
            fill_ff[w] <= '0;
         end
      end else begin
         for (int w = 0; w < NUM_WINDOWS; w++) begin
            type_ff[w] <= type_in[w];
            bus_ff[w]  <= bus_in[w];
            host_ff[w] <= host_in[w];
            size_ff[w] <= size_in[w];
            fill_ff[w] <= fill_in[w];
         end
      end
   end

   always_comb begin
      unique case (wr_reg)
         REG_TYPE:      prdata = PDATA_WIDTH'(type_ff[wr_win]);
         REG_BUS_BASE:  prdata = PDATA_WIDTH'(bus_ff[wr_win]);
         REG_HOST_BASE: prdata = PDATA_WIDTH'(host_ff[wr_win]);
         REG_LENGTH:    prdata = PDATA_WIDTH'(size_ff[wr_win]);
         default:       prdata = '0;
      endcase
   end

   always_comb begin
      win_view.kind        = type_ff[win_sel];
      win_view.bus_base    = bus_ff[win_sel];
      win_view.host_origin = host_ff[win_sel];
      win_view.size        = size_ff[win_sel];
      win_view.fill        = fill_ff[win_sel];
   end

endmodule

// File: sv/awa_alu.sv
// ----------------------------------------------------------------------------
// awa_alu: shared address adder
// One wide adder with an operand selector; the sequencer steps it through
// the mask, rounding, end and address computations of a request.
// ----------------------------------------------------------------------------
module awa_alu (
   input  awa_pkg::alu_op_type             alu_op,
   input  awa_pkg::alu_src_type            alu_src,
   output logic [awa_pkg::CALC_WIDTH-1:0]  alu_sum
);
   import awa_pkg::*;

   logic [CALC_WIDTH-1:0] opa;
   logic [CALC_WIDTH-1:0] opb;

   always_comb begin
      unique case (alu_op)
         ALU_DEC: begin
            // Adding all ones subtracts one.
            opa = CALC_WIDTH'(alu_src.size);
            opb = '1;
         end
         ALU_ROUND: begin
            opa = CALC_WIDTH'(alu_src.fill);
            opb = CALC_WIDTH'(alu_src.mask);
         end
         ALU_END: begin
            opa = CALC_WIDTH'(alu_src.off);
            opb = CALC_WIDTH'(alu_src.size);
         end
         ALU_BUS: begin
            opa = CALC_WIDTH'(alu_src.bus_base);
            opb = CALC_WIDTH'(alu_src.off);
         end
         ALU_HOST: begin
            opa = CALC_WIDTH'(alu_src.host_origin);
            opb = CALC_WIDTH'(alu_src.off);
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   assign alu_sum = opa + opb;

endmodule

// File: sv/awa_seq.sv
// ----------------------------------------------------------------------------
// awa_seq: request sequencer
// Walks the windows in order for one request, drives the shared adder,
// updates the fill offset on a grant and holds the response register.
// ----------------------------------------------------------------------------
module awa_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  awa_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output awa_pkg::rsp_type                  rsp_data,
   input  awa_pkg::win_view_type             win_view,
   output logic [awa_pkg::WIN_IDX_WIDTH-1:0] win_sel,
   output awa_pkg::fill_upd_type             fill_upd,
   output awa_pkg::alu_op_type               alu_op,
   output awa_pkg::alu_src_type              alu_src,
   input  logic [awa_pkg::CALC_WIDTH-1:0]    alu_sum
);
   import awa_pkg::*;

   seq_state_type            state_ff, state_in;
   logic [WIN_IDX_WIDTH-1:0] win_ff, win_in;
   logic [KIND_WIDTH-1:0]    kind_ff, kind_in;
   logic [ADDR_WIDTH-1:0]    size_ff, size_in;
   logic [ADDR_WIDTH-1:0]    mask_ff, mask_in;
   logic [OFF_WIDTH-1:0]     off_ff, off_in;
   logic [ADDR_WIDTH-1:0]    bus_ff, bus_in;
   logic [ADDR_WIDTH-1:0]    host_ff, host_in;
   logic [STATUS_WIDTH-1:0]  status_ff, status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;
   logic                     last_win;
   logic                     kind_ok;

   assign last_win = (win_ff == WIN_IDX_WIDTH'(NUM_WINDOWS - 1));
   assign kind_ok  = (kind_ff == KIND_IO) || (kind_ff == KIND_MEM);

   always_comb begin
      alu_src.size        = size_ff;
      alu_src.mask        = mask_ff;
      alu_src.fill        = win_view.fill;
      alu_src.off         = off_ff;
      alu_src.bus_base    = win_view.bus_base;
      alu_src.host_origin = win_view.host_origin;
   end

   always_comb begin
      state_in       = state_ff;
      win_in         = win_ff;
      kind_in        = kind_ff;
      size_in        = size_ff;
      mask_in        = mask_ff;
      off_in         = off_ff;
      bus_in         = bus_ff;
      host_in        = host_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_data_in    = rsp_data_ff;
      alu_op         = ALU_NOP;
      fill_upd.en    = 1'b0;
      fill_upd.win   = win_ff;
      fill_upd.value = alu_sum[FILL_WIDTH-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in  = req_data.req_kind;
               size_in  = req_data.req_size;
               win_in   = '0;
               state_in = ST_MASK;
            end
         end
         ST_MASK: begin
            alu_op  = ALU_DEC;
            mask_in = alu_sum[ADDR_WIDTH-1:0];
            if (size_ff == '0) begin
               status_in = STATUS_ZERO;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            if (kind_ok && win_view.kind == kind_ff) begin
               state_in = ST_ROUND;
            end else if (last_win) begin
               status_in = STATUS_NOSPACE;
               state_in  = ST_DONE;
            end else begin
               win_in   = win_ff + 1'b1;
               state_in = ST_SELECT;
            end
         end
         ST_ROUND: begin
            alu_op   = ALU_ROUND;
            off_in   = alu_sum[OFF_WIDTH-1:0] & ~OFF_WIDTH'(mask_ff);
            state_in = ST_END;
         end
         ST_END: begin
            alu_op = ALU_END;
            // The end is compared at full width so that nothing wraps.
            if (alu_sum <= CALC_WIDTH'(win_view.size)) begin
               fill_upd.en = 1'b1;
               state_in    = ST_BUS;
            end else if (last_win) begin
               status_in = STATUS_NOSPACE;
               state_in  = ST_DONE;
            end else begin
               win_in   = win_ff + 1'b1;
               state_in = ST_SELECT;
            end
         end
         ST_BUS: begin
            alu_op   = ALU_BUS;
            bus_in   = alu_sum[ADDR_WIDTH-1:0];
            state_in = ST_HOST;
         end
         ST_HOST: begin
            alu_op    = ALU_HOST;
            host_in   = alu_sum[ADDR_WIDTH-1:0];
            status_in = STATUS_GRANT;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.status = status_ff;
               if (status_ff == STATUS_GRANT) begin
                  rsp_data_in.bus_addr  = bus_ff;
                  rsp_data_in.host_addr = host_ff;
               end else begin
                  rsp_data_in.bus_addr  = '0;
                  rsp_data_in.host_addr = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         win_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_ff       <= win_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      size_ff     <= size_in;
      mask_ff     <= mask_in;
      off_ff      <= off_in;
      bus_ff      <= bus_in;
      host_ff     <= host_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign win_sel   = win_ff;

endmodule

// File: sv/aligned_window_allocator_core.sv
// ----------------------------------------------------------------------------
// aligned_window_allocator_core: aligned address allocator over two windows
// Hands out ranges from two bus windows, aligned to power-of-two request
// sizes, and reports both the bus-side and host-side address of each grant.
// ----------------------------------------------------------------------------
// One request beat is handled at a time; req_ready is high only while the
// block is idle. All arithmetic runs on a single shared 51-bit adder stepped
// by a small sequencer, so the time to a response is set by the adder steps:
// a zero size answers after the mask step; each window is checked for kind,
// one of the wanted kind goes through the rounding and end steps, one with
// no room passes on to the next, and a grant adds the bus and host address
// steps. The next request is taken in the cycle after the response register
// is loaded, even while that response still waits on rsp_ready. Writing a
// window's size register restarts its fill offset at zero; registers must be
// written only while no request is in flight; the block does not enforce it.
module aligned_window_allocator_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  awa_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output awa_pkg::rsp_type                rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [awa_pkg::PADDR_WIDTH-1:0] paddr,
   input  logic [awa_pkg::PDATA_WIDTH-1:0] pwdata,
   output logic [awa_pkg::PDATA_WIDTH-1:0] prdata,
   output logic                            pready
);
   import awa_pkg::*;

   win_view_type             win_view;
   logic [WIN_IDX_WIDTH-1:0] win_sel;
   fill_upd_type             fill_upd;
   alu_op_type               alu_op;
   alu_src_type              alu_src;
   logic [CALC_WIDTH-1:0]    alu_sum;

   assign pready = 1'b1;

   awa_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .win_sel  (win_sel),
      .fill_upd (fill_upd),
      .win_view (win_view)
   );

   awa_alu u_alu (
      .alu_op  (alu_op),
      .alu_src (alu_src),
      .alu_sum (alu_sum)
   );

   awa_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .win_view  (win_view),
      .win_sel   (win_sel),
      .fill_upd  (fill_upd),
      .alu_op    (alu_op),
      .alu_src   (alu_src),
      .alu_sum   (alu_sum)
   );

`ifndef SYNTHESIS
   // A response that is not a grant carries no addresses.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_GRANT
      |-> rsp_data.bus_addr == '0 && rsp_data.host_addr == '0)
      else $error("non-grant response carries an address");

   // The block is busy in the cycle after it takes a request.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a request is in flight");

   // A fill offset never moves past the end of its window.
   assert property (@(posedge clock) disable iff (reset)
      fill_upd.en |-> fill_upd.value <= FILL_WIDTH'(win_view.size))
      else $error("fill offset advanced past window size");

   // The fill offset only advances while the shared adder computes the end.
   assert property (@(posedge clock) disable iff (reset)
      fill_upd.en |-> alu_op == ALU_END && fill_upd.win == win_sel)
      else $error("fill offset written outside the end step");
`endif

endmodule

// File: tb/aligned_window_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// aligned_window_allocator_core_tb: self-checking bench for the allocator core
// A table of directed beats covers the reset state, zero sizes, bad kinds,
// rounding, wrap of the bases and register truncation. Random phases follow,
// each with a fresh window setup. Every response is checked field by field
// against the bench's allocation predictor or a directed beat's fixed value.
// ----------------------------------------------------------------------------
module aligned_window_allocator_core_tb;
   import awa_pkg::*;

   localparam int ITEMS_PER_PHASE = 140;
   localparam int NUM_PHASES      = 12;
   localparam int DRAIN_CYCLES    = 16;
   localparam int LONG_HOLD       = 400;

   // A request kind that no window can ever match.
   localparam logic [KIND_WIDTH-1:0] KIND_BAD = 2'd3;

   typedef enum logic {ROW_WRITE, ROW_REQ} row_kind_type;
   typedef enum logic [1:0] {PACE_OPEN, PACE_COIN, PACE_EVERY4, PACE_MOSTLY} pace_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [2:0]             reg_idx;
      logic [PDATA_WIDTH-1:0] wdata;
      req_type                req;
      logic                   typed_on;
      rsp_type                typed_rsp;
   } plan_row_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   psel      = 1'b0;
   logic                   penable   = 1'b0;
   logic                   pwrite    = 1'b0;
   logic [PADDR_WIDTH-1:0] paddr     = '0;
   logic [PDATA_WIDTH-1:0] pwdata    = '0;
   logic [PDATA_WIDTH-1:0] prdata;
   logic                   pready;

   // Predictor copy of the window registers and fill offsets.
   logic [KIND_WIDTH-1:0] win_kind [NUM_WINDOWS];
   logic [ADDR_WIDTH-1:0] win_bus  [NUM_WINDOWS];
   logic [ADDR_WIDTH-1:0] win_host [NUM_WINDOWS];
   logic [ADDR_WIDTH-1:0] win_len  [NUM_WINDOWS];
   logic [FILL_WIDTH-1:0] win_fill [NUM_WINDOWS];

   rsp_type      pending_allocs[$];
   plan_row_type plan[$];
   int           mismatch_count = 0;
   int           burst_left     = 0;
   bit           gaps_on        = 1'b1;
   bit           hold_request   = 1'b0;

   aligned_window_allocator_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #5 clock = ~clock;

   function automatic logic [ADDR_WIDTH-1:0] rand48();
      logic [63:0] t;
      t = {$urandom, $urandom};
      return t[ADDR_WIDTH-1:0];
   endfunction

   // First window of the wanted kind that still has room after the fill
   // offset is rounded up to the request size.
   function automatic rsp_type predict_allocation(input req_type item);
      rsp_type     res;
      logic [63:0] sz;
      logic [63:0] rounded;
      logic [63:0] span_end;
      bit          granted;
      res        = '0;
      res.status = STATUS_NOSPACE;
      granted    = 1'b0;
      sz         = {16'd0, item.req_size};
      if (sz == 64'd0) begin
         res.status = STATUS_ZERO;
      end else if (item.req_kind == KIND_IO || item.req_kind == KIND_MEM) begin
         for (int w = 0; w < NUM_WINDOWS; w++) begin
            if (!granted && win_kind[w] == item.req_kind) begin
               rounded  = ({15'd0, win_fill[w]} + sz - 64'd1) & ~(sz - 64'd1);
               span_end = rounded + sz;
               if (span_end <= {16'd0, win_len[w]}) begin
                  granted       = 1'b1;
                  win_fill[w]   = span_end[FILL_WIDTH-1:0];
                  res.status    = STATUS_GRANT;
                  res.bus_addr  = win_bus[w] + rounded[ADDR_WIDTH-1:0];
                  res.host_addr = win_host[w] + rounded[ADDR_WIDTH-1:0];
               end
            end
         end
      end
      return res;
   endfunction

   function automatic req_type gen_request(input int exp_hi);
      req_type r;
      int      pick;
      pick = $urandom_range(0, 19);
      if (pick == 0)
         r.req_kind = KIND_OFF;
      else if (pick == 1)
         r.req_kind = KIND_BAD;
      else
         r.req_kind = (pick % 2 == 0) ? KIND_IO : KIND_MEM;
      pick = $urandom_range(0, 99);
      if (pick < 3)
         r.req_size = '0;
      else if (pick < 8)
         r.req_size = rand48();
      else if (pick < 10)
         r.req_size = '1;
      else if (pick < 14)
         r.req_size = 48'd1 << $urandom_range(0, ADDR_WIDTH - 1);
      else
         r.req_size = 48'd1 << $urandom_range(0, exp_hi);
      return r;
   endfunction

   task automatic add_write(input logic [2:0] idx, input logic [PDATA_WIDTH-1:0] value);
      plan_row_type row;
      row         = '0;
      row.kind    = ROW_WRITE;
      row.reg_idx = idx;
      row.wdata   = value;
      plan.push_back(row);
   endtask

   task automatic add_req(input logic [KIND_WIDTH-1:0] kind, input logic [ADDR_WIDTH-1:0] size);
      plan_row_type row;
      row              = '0;
      row.kind         = ROW_REQ;
      row.req.req_kind = kind;
      row.req.req_size = size;
      plan.push_back(row);
   endtask

   task automatic add_req_typed(input logic [KIND_WIDTH-1:0] kind,
                                input logic [ADDR_WIDTH-1:0] size,
                                input logic [STATUS_WIDTH-1:0] status,
                                input logic [ADDR_WIDTH-1:0] bus_addr,
                                input logic [ADDR_WIDTH-1:0] host_addr);
      plan_row_type row;
      row                     = '0;
      row.kind                = ROW_REQ;
      row.req.req_kind        = kind;
      row.req.req_size        = size;
      row.typed_on            = 1'b1;
      row.typed_rsp.status    = status;
      row.typed_rsp.bus_addr  = bus_addr;
      row.typed_rsp.host_addr = host_addr;
      plan.push_back(row);
   endtask

   // Setup cycle, then access cycle; the register takes the value at the
   // edge that closes the access cycle.
   task automatic csr_write(input logic [2:0] idx, input logic [PDATA_WIDTH-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx[1:0])
         REG_TYPE:      win_kind[idx[2]] = value[KIND_WIDTH-1:0];
         REG_BUS_BASE:  win_bus[idx[2]]  = value[ADDR_WIDTH-1:0];
         REG_HOST_BASE: win_host[idx[2]] = value[ADDR_WIDTH-1:0];
         default: begin
            win_len[idx[2]]  = value[ADDR_WIDTH-1:0];
            win_fill[idx[2]] = '0;
         end
      endcase
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_request(input req_type item, input bit typed_on, input rsp_type typed_rsp);
      rsp_type predicted;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predicted = predict_allocation(item);
      pending_allocs.push_back(typed_on ? typed_rsp : predicted);
   endtask

   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = gaps_on ? $urandom_range(0, 10) : 0;
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_allocs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : rsp_pacer
      pace_type mode;
      int       mode_left;
      int       hold_left;
      mode      = PACE_OPEN;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
         end
         if (mode_left == 0) begin
            mode      = pace_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 300);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               PACE_OPEN:   rsp_ready <= 1'b1;
               PACE_COIN:   rsp_ready <= ($urandom_range(0, 1) == 1);
               PACE_EVERY4: rsp_ready <= (mode_left % 4 == 0);
               default:     rsp_ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_allocs.size() == 0) begin
            $display("%0t: response beat with nothing outstanding: %h", $time, rsp_data);
            mismatch_count++;
         end else begin
            want = pending_allocs.pop_front();
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d, got %0d", $time, want.status,
                        rsp_data.status);
               mismatch_count++;
            end
            if (rsp_data.bus_addr !== want.bus_addr) begin
               $display("%0t: bus_addr expected %h, got %h", $time, want.bus_addr,
                        rsp_data.bus_addr);
               mismatch_count++;
            end
            if (rsp_data.host_addr !== want.host_addr) begin
               $display("%0t: host_addr expected %h, got %h", $time, want.host_addr,
                        rsp_data.host_addr);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : stimulus
      plan_row_type          row;
      int                    pick;
      int                    scale;
      int                    exp_hi;
      logic [KIND_WIDTH-1:0] kind;
      logic [ADDR_WIDTH-1:0] bus;
      logic [ADDR_WIDTH-1:0] host;
      logic [ADDR_WIDTH-1:0] len;

      for (int w = 0; w < NUM_WINDOWS; w++) begin
         win_kind[w] = KIND_OFF;
         win_bus[w]  = '0;
         win_host[w] = '0;
         win_len[w]  = '0;
         win_fill[w] = '0;
      end

      // Straight out of reset every window is disabled.
      add_req_typed(KIND_IO, 48'd1, STATUS_NOSPACE, '0, '0);
      add_req_typed(KIND_MEM, 48'd0, STATUS_ZERO, '0, '0);
      add_write({1'b0, REG_TYPE}, 64'(KIND_IO));
      add_write({1'b0, REG_BUS_BASE}, 64'h1000);
      add_write({1'b0, REG_HOST_BASE}, 64'hFFFF_FFFF_F000);
      add_write({1'b0, REG_LENGTH}, 64'h100);
      add_write({1'b1, REG_TYPE}, 64'(KIND_MEM));
      add_write({1'b1, REG_BUS_BASE}, 64'hFFFF_FFFF_FF00);
      // Only the upper bits are set, so the register must come out as zero.
      add_write({1'b1, REG_HOST_BASE}, 64'hFFFF_0000_0000_0000);
      add_write({1'b1, REG_LENGTH}, 64'hFFFF_FFFF_FFFF);
      add_req_typed(KIND_IO, 48'h10, STATUS_GRANT, 48'h1000, 48'hFFFF_FFFF_F000);
      add_req(KIND_IO, 48'h1);
      add_req(KIND_IO, 48'h40);
      add_req(KIND_IO, 48'h3);
      add_req(KIND_IO, 48'h100);
      add_req_typed(KIND_OFF, 48'd1, STATUS_NOSPACE, '0, '0);
      add_req_typed(KIND_BAD, 48'd1, STATUS_NOSPACE, '0, '0);
      add_req(KIND_MEM, 48'h8000_0000_0000);
      add_req(KIND_MEM, 48'h8000_0000_0000);
      add_req(KIND_MEM, 48'h1);
      add_req(KIND_MEM, 48'hFFFF_FFFF_FFFF);
      add_req_typed(KIND_OFF, 48'd0, STATUS_ZERO, '0, '0);
      // Rewriting the size starts window 0 over at offset zero.
      add_write({1'b0, REG_LENGTH}, 64'h200);
      add_req_typed(KIND_IO, 48'h80, STATUS_GRANT, 48'h1000, 48'hFFFF_FFFF_F000);
      add_write({1'b0, REG_TYPE}, 64'(KIND_MEM));
      add_write({1'b0, REG_BUS_BASE}, 64'hFFFF_FFFF_FFFF);
      add_write({1'b0, REG_HOST_BASE}, 64'hFFFF_FFFF_FFFF);
      add_write({1'b0, REG_LENGTH}, 64'hFFFF_FFFF_FFFF);
      // Truncates to kind 3, which must behave like a disabled window.
      add_write({1'b1, REG_TYPE}, 64'hFFFF_FFFF_FFFF_FFFF);
      add_req_typed(KIND_MEM, 48'hFFFF_FFFF_FFFF, STATUS_GRANT, 48'hFFFF_FFFF_FFFF,
                    48'hFFFF_FFFF_FFFF);
      add_req(KIND_MEM, 48'h1);
      add_req_typed(KIND_IO, 48'd1, STATUS_NOSPACE, '0, '0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      while (plan.size() != 0) begin
         row = plan.pop_front();
         if (row.kind == ROW_WRITE) begin
            wait_drained();
            csr_write(row.reg_idx, row.wdata);
         end else begin
            pace_sender();
            send_request(row.req, row.typed_on, row.typed_rsp);
         end
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_drained();
         exp_hi  = 0;
         gaps_on = (ph % 3 != 2);
         for (int w = 0; w < NUM_WINDOWS; w++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
               kind = KIND_OFF;
            else if (pick == 1)
               kind = KIND_BAD;
            else
               kind = (pick % 2 == 0) ? KIND_IO : KIND_MEM;
            bus   = rand48();
            host  = rand48();
            scale = $urandom_range(4, ADDR_WIDTH - 1);
            len   = (48'd1 << scale) | (rand48() & ((48'd1 << scale) - 48'd1));
            if ($urandom_range(0, 5) == 0) bus = '1;
            if ($urandom_range(0, 5) == 0) host = '0;
            if (ph == 0) begin
               kind  = (w == 0) ? KIND_IO : KIND_MEM;
               bus   = '1;
               host  = '1;
               len   = '1;
               scale = ADDR_WIDTH - 1;
            end else if (ph == 1) begin
               len   = '0;
               scale = 12;
            end else if (ph == 2) begin
               bus   = '0;
               host  = '0;
               len   = 48'd1;
               scale = 5;
            end
            if (scale - 5 > exp_hi) exp_hi = scale - 5;
            csr_write({1'(w), REG_TYPE}, {rand48(), 14'd0, kind});
            csr_write({1'(w), REG_BUS_BASE}, {16'($urandom), bus});
            csr_write({1'(w), REG_HOST_BASE}, {16'($urandom), host});
            csr_write({1'(w), REG_LENGTH}, {16'($urandom), len});
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // The receiver goes quiet for a long stretch while beats keep coming.
            if (n == 40 && ph % 4 == 3) hold_request = 1'b1;
            if (n == 90 && ph % 4 == 1) wait_drained();
            pace_sender();
            send_request(gen_request(exp_hi), 1'b0, '0);
         end
      end

      wait_drained();
      if (mismatch_count == 0 && pending_allocs.size() == 0)
         $display("** aligned_window_allocator_core: PASSED **");
      else
         $display("** aligned_window_allocator_core: FAILED **");
      $finish;
   end

   initial begin : watchdog
      #3_000_000;
      $display("** aligned_window_allocator_core: FAILED **");
      $finish;
   end

endmodule
